// File: rtl/eabv_pkg.sv
// Package: shared constants and CORDIC angle table.
`timescale 1ns / 1ps
package eabv_pkg;
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 14;
    localparam int OUT_W             = 16;
    localparam int CORDIC_STEPS      = 30;
    localparam int ZW                = 32;   // residual angle, 2^-32 turn units
    localparam int XW                = 33;   // CORDIC x/y, Q2.30 plus sign headroom
    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    function automatic logic signed [ZW-1:0] atan_turn32(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        unique case (i)
            5'd0:  r = 32'h20000000; 5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B; 5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43; 5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E; 5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53; 5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2FA; 5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C; 5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A; 5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage

// File: rtl/eabv_front.sv
// Front: align angles to 32-bit turns, run pipelined CORDIC, round to sin/cos.
`timescale 1ns / 1ps
module eabv_front import eabv_pkg::*; #(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int VW = FRACTION_BITS + 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    input  logic [ANGLE_BITS-1:0] in_angle [3],
    input  logic                  advance,
    output logic                  out_valid,
    output logic signed [VW-1:0]  out_sin [3],
    output logic signed [VW-1:0]  out_cos [3]
);
    localparam int NS = CORDIC_STEPS;
    localparam int SH = 30 - FRACTION_BITS;
    localparam logic signed [VW-1:0] ONE = VW'(1) <<< FRACTION_BITS;

    logic                 vld_reg [NS+1];
    logic signed [XW-1:0] x_reg [NS+1][3];
    logic signed [XW-1:0] y_reg [NS+1][3];
    logic signed [ZW-1:0] z_reg [NS+1][3];
    logic [1:0]           q_reg [NS+1][3];

    // Load: shift angle to 32-bit turn, split quadrant and residual
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg[0] <= 1'b0;
        else if (advance) vld_reg[0] <= in_valid;
        if (advance) begin
            for (int k = 0; k < 3; k++) begin
                logic [31:0] t;
                t = {in_angle[k], {(32-ANGLE_BITS){1'b0}}};
                q_reg[0][k] <= t[31:30];
                z_reg[0][k] <= {2'b00, t[29:0]};
                x_reg[0][k] <= CORDIC_GAIN_Q30;
                y_reg[0][k] <= '0;
            end
        end
    end

    // Advance one micro-rotation per stage
    for (genvar i = 0; i < NS; i++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) vld_reg[i+1] <= 1'b0;
            else if (advance) vld_reg[i+1] <= vld_reg[i];
            if (advance) begin
                for (int k = 0; k < 3; k++) begin
                    if (!z_reg[i][k][ZW-1]) begin
                        x_reg[i+1][k] <= x_reg[i][k] - (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] + (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] - atan_turn32(5'(i));
                    end else begin
                        x_reg[i+1][k] <= x_reg[i][k] + (y_reg[i][k] >>> i);
                        y_reg[i+1][k] <= y_reg[i][k] - (x_reg[i][k] >>> i);
                        z_reg[i+1][k] <= z_reg[i][k] + atan_turn32(5'(i));
                    end
                    q_reg[i+1][k] <= q_reg[i][k];
                end
            end
        end
    end

    function automatic logic signed [VW-1:0] to_frac(input logic signed [XW-1:0] v);
        logic signed [XW:0] r;
        r = (SH == 0) ? XW'(v) : ((XW+1)'(v) + ((XW+1)'(1) <<< (SH > 0 ? SH-1 : 0))) >>> SH;
        if (r > (XW+1)'(ONE)) return ONE;
        if (r < -(XW+1)'(ONE)) return -ONE;
        return VW'(r);
    endfunction

    // Round, clamp and fold quadrant
    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid <= 1'b0;
        else if (advance) out_valid <= vld_reg[NS];
        if (advance) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [VW-1:0] c, s;
                c = to_frac(x_reg[NS][k]);
                s = to_frac(y_reg[NS][k]);
                unique case (q_reg[NS][k])
                    2'd0: begin out_cos[k] <= c;  out_sin[k] <= s;  end
                    2'd1: begin out_cos[k] <= -s; out_sin[k] <= c;  end
                    2'd2: begin out_cos[k] <= -c; out_sin[k] <= -s; end
                    default: begin out_cos[k] <= s; out_sin[k] <= -c; end
                endcase
            end
        end
    end
endmodule

// File: rtl/eabv_back.sv
// Back: form the basis vector components from sin/cos with two product stages.
`timescale 1ns / 1ps
module eabv_back import eabv_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int VW = FRACTION_BITS + 2
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic signed [VW-1:0] in_sin [3],
    input  logic signed [VW-1:0] in_cos [3],
    input  logic                 advance,
    output logic                 out_valid,
    output logic [OUT_W-1:0]     out_comp [9]
);
    localparam int PW = 2*VW;
    localparam logic signed [VW+1:0] ONE = (VW+2)'(1) <<< FRACTION_BITS;

    function automatic logic signed [VW-1:0] fmul(input logic signed [VW-1:0] a,
                                                  input logic signed [VW-1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b) + (PW'(1) <<< (FRACTION_BITS-1));
        return VW'(p >>> FRACTION_BITS);
    endfunction

    function automatic logic [OUT_W-1:0] pack(input logic signed [VW+1:0] v);
        logic signed [VW+1:0] c;
        c = (v > ONE) ? ONE : ((v < -ONE) ? -ONE : v);
        return OUT_W'(c);
    endfunction

    logic                 v1_reg, v2_reg;
    logic signed [VW-1:0] sy_reg, cy_reg, sp_reg, sr_reg, cr_reg;
    logic signed [VW-1:0] srsp_reg, crsp_reg, cpcy_reg, cpsy_reg, srcp_reg, crcp_reg;

    // Stage 1: first-level products
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (advance) v1_reg <= in_valid;
        if (advance) begin
            srsp_reg <= fmul(in_sin[2], in_sin[1]);
            crsp_reg <= fmul(in_cos[2], in_sin[1]);
            cpcy_reg <= fmul(in_cos[1], in_cos[0]);
            cpsy_reg <= fmul(in_cos[1], in_sin[0]);
            srcp_reg <= fmul(in_sin[2], in_cos[1]);
            crcp_reg <= fmul(in_cos[2], in_cos[1]);
            sy_reg <= in_sin[0]; cy_reg <= in_cos[0];
            sp_reg <= in_sin[1];
            sr_reg <= in_sin[2]; cr_reg <= in_cos[2];
        end
    end

    // Stage 2: second-level products, sums and saturation
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (advance) v2_reg <= v1_reg;
        if (advance) begin
            out_comp[0] <= pack((VW+2)'(cpcy_reg));
            out_comp[1] <= pack((VW+2)'(cpsy_reg));
            out_comp[2] <= pack(-(VW+2)'(sp_reg));
            out_comp[3] <= pack(-(VW+2)'(fmul(srsp_reg, cy_reg)) + (VW+2)'(fmul(cr_reg, sy_reg)));
            out_comp[4] <= pack(-(VW+2)'(fmul(srsp_reg, sy_reg)) - (VW+2)'(fmul(cr_reg, cy_reg)));
            out_comp[5] <= pack(-(VW+2)'(srcp_reg));
            out_comp[6] <= pack((VW+2)'(fmul(crsp_reg, cy_reg)) + (VW+2)'(fmul(sr_reg, sy_reg)));
            out_comp[7] <= pack((VW+2)'(fmul(crsp_reg, sy_reg)) - (VW+2)'(fmul(sr_reg, cy_reg)));
            out_comp[8] <= pack((VW+2)'(crcp_reg));
        end
    end
    assign out_valid = v2_reg;
endmodule

// File: rtl/eabv_queue.sv
// Two-entry output queue that decouples the pipeline from the receiver.
`timescale 1ns / 1ps
module eabv_queue import eabv_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  logic [OUT_W-1:0] in_comp [9],
    output logic             in_ready,
    output logic             out_valid,
    output logic [OUT_W-1:0] out_comp [9],
    input  logic             out_ready
);
    logic [OUT_W-1:0] mem_reg [2][9];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_comp  = mem_reg[rp_reg];

    // Push and pop words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (out_valid && out_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
        if (in_valid && in_ready) mem_reg[wp_reg] <= in_comp;
    end
endmodule

// File: rtl/euler_angles_to_basis_vectors.sv
// Top level: Euler angles to forward, right and up basis vectors.
// Usage:
//   Input channel s_valid/s_ready carries one word of yaw, pitch and roll
//   binary angles (2^ANGLE_BITS per turn). Output channel m_valid/m_ready
//   carries nine signed Q1.14 components per word, one word per input word.
// Throughput: one word per cycle while the receiver takes words.
// Pipeline: 31 CORDIC stages, one rounding stage, two product stages and
//   one queue stage lie between acceptance and m_valid; the 30-stage
//   CORDIC micro-rotation pipeline is the largest part.
// Stall: the whole pipeline moves only when its last stage is empty or its
//   word can enter the two-entry output queue; s_ready falls otherwise.
// Reset: aresetn synchronous active low clears all valid flags and the
//   queue; no word is in flight after reset.
`timescale 1ns / 1ps
module euler_angles_to_basis_vectors import eabv_pkg::*; #(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [ANGLE_BITS-1:0] s_yaw_angle,
    input  logic [ANGLE_BITS-1:0] s_pitch_angle,
    input  logic [ANGLE_BITS-1:0] s_roll_angle,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [OUT_W-1:0] m_forward_x,
    output logic signed [OUT_W-1:0] m_forward_y,
    output logic signed [OUT_W-1:0] m_forward_z,
    output logic signed [OUT_W-1:0] m_right_x,
    output logic signed [OUT_W-1:0] m_right_y,
    output logic signed [OUT_W-1:0] m_right_z,
    output logic signed [OUT_W-1:0] m_up_x,
    output logic signed [OUT_W-1:0] m_up_y,
    output logic signed [OUT_W-1:0] m_up_z
);
    localparam int VW = FRACTION_BITS + 2;
    logic                  advance, f_valid, b_valid, q_ready;
    logic [ANGLE_BITS-1:0] ang [3];
    logic signed [VW-1:0]  sn [3], cs [3];
    logic [OUT_W-1:0]      b_comp [9], q_comp [9];

    // Stall the pipeline only when its output word cannot enter the queue
    assign advance = q_ready || !b_valid;
    assign s_ready = advance;
    assign ang[0] = s_yaw_angle;
    assign ang[1] = s_pitch_angle;
    assign ang[2] = s_roll_angle;

    eabv_front #(.ANGLE_BITS(ANGLE_BITS), .FRACTION_BITS(FRACTION_BITS)) u_front (
        .aclk, .aresetn, .in_valid(s_valid), .in_angle(ang), .advance,
        .out_valid(f_valid), .out_sin(sn), .out_cos(cs));

    eabv_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk, .aresetn, .in_valid(f_valid), .in_sin(sn), .in_cos(cs), .advance,
        .out_valid(b_valid), .out_comp(b_comp));

    eabv_queue u_queue (
        .aclk, .aresetn, .in_valid(b_valid && advance), .in_comp(b_comp),
        .in_ready(q_ready), .out_valid(m_valid), .out_comp(q_comp), .out_ready(m_ready));

    assign m_forward_x = q_comp[0];
    assign m_forward_y = q_comp[1];
    assign m_forward_z = q_comp[2];
    assign m_right_x   = q_comp[3];
    assign m_right_y   = q_comp[4];
    assign m_right_z   = q_comp[5];
    assign m_up_x      = q_comp[6];
    assign m_up_y      = q_comp[7];
    assign m_up_z      = q_comp[8];
endmodule

// File: rtl/eabv_checker.sv
// Checker: port-level assertions for the basis vector block, with bind.
`timescale 1ns / 1ps
module eabv_checker import eabv_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [OUT_W-1:0] m_forward_z,
    input logic [OUT_W-1:0] m_up_z
);
    // Hold a stalled output word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_forward_z) && $stable(m_up_z))
        else $error("output word changed while stalled");
    // Nothing comes out right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");
    // Keep taking input when receiver takes output
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready && $past(m_ready) && $past(aresetn) |-> s_ready)
        else $error("input stalled with receiver ready");
    // The up z component stays within plus or minus one
    a_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_up_z) <= 16384) && ($signed(m_up_z) >= -16384))
        else $error("component out of range");
endmodule

bind euler_angles_to_basis_vectors eabv_checker u_eabv_checker (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .m_forward_z, .m_up_z);
